/* hdl/bevc_pkg.sv */
// ----------------------------------------------------------------------------
// bevc_pkg: shared definitions for the big-endian base-128 varint codec
// Field widths, codes, the shift unit mode and small helper functions.
// ----------------------------------------------------------------------------
package bevc_pkg;

  localparam int unsigned MAX_BYTES = 10;
  localparam int unsigned GRP_W     = 7;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RSEL_16 = 2'd0,
    RSEL_32 = 2'd1,
    RSEL_64 = 2'd2
  } rsel_t;

  typedef enum logic {
    SH_ENC_RIGHT = 1'b0,
    SH_DEC_LEFT  = 1'b1
  } sh_mode_t;

  // Selects 7-bit group idx of a 64-bit value; the top group holds bit 63 only.
  function automatic logic [GRP_W-1:0] get_group(input logic [VAL_W-1:0] v,
                                                 input logic [CNT_W-1:0] idx);
    logic [GRP_W-1:0] g;
    case (idx)
      4'd0:    g = v[6:0];
      4'd1:    g = v[13:7];
      4'd2:    g = v[20:14];
      4'd3:    g = v[27:21];
      4'd4:    g = v[34:28];
      4'd5:    g = v[41:35];
      4'd6:    g = v[48:42];
      4'd7:    g = v[55:49];
      4'd8:    g = v[62:56];
      4'd9:    g = {6'd0, v[63]};
      default: g = '0;
    endcase
    return g;
  endfunction

  // A signed value fits 16 or 32 bits when every bit above the sign is a copy of it.
  function automatic logic fits_range(input logic [VAL_W-1:0] v, input logic [1:0] sel);
    logic ok;
    case (sel)
      RSEL_16: ok = (&v[63:15]) | ~(|v[63:15]);
      RSEL_32: ok = (&v[63:31]) | ~(|v[63:31]);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

/* hdl/bevc_shift_unit.sv */
// ----------------------------------------------------------------------------
// bevc_shift_unit: shared 7-bit group shifter
// Shifts right by one group when sizing an encode, or shifts a received
// group in from the bottom when accumulating a decode.
// ----------------------------------------------------------------------------
module bevc_shift_unit (
  input  bevc_pkg::sh_mode_t        mode,
  input  logic [bevc_pkg::VAL_W-1:0] operand,
  input  logic [bevc_pkg::GRP_W-1:0] grp_in,
  output logic [bevc_pkg::VAL_W-1:0] result
);
  import bevc_pkg::*;

  always_comb begin
    unique case (mode)
      SH_ENC_RIGHT: result = {{GRP_W{1'b0}}, operand[VAL_W-1:GRP_W]};
      SH_DEC_LEFT:  result = {operand[VAL_W-GRP_W-1:0], grp_in};
      default:      result = '0;
    endcase
  end

endmodule

/* hdl/big_endian_varint_codec_core.sv */
// ----------------------------------------------------------------------------
// big_endian_varint_codec_core: 64-bit big-endian base-128 varint codec
// Encode: an accepted word yields 1 to 10 output words, top group first.
// Sizing runs group by group on the shared shifter; then one output word is
// emitted per cycle while out_tready allows. Decode: each byte is folded in before
// the next is taken; a terminating byte, or the tenth, gives one word.
// Reset (synchronous, rst_n low) clears the sequencer, accumulator and count.
// ----------------------------------------------------------------------------
module big_endian_varint_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // value[63:0], in_byte[71:64], range_sel[73:72], zero pad
  input  logic        in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata, // out_byte[7:0], dec_value[71:8], byte_count[75:72],
                                 // status[77:76], zero pad
  output logic        out_tuser, // kind
  output logic        out_tlast  // last
);
  import bevc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_EMIT  = 4'b0100,
    S_DEC   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  work_r, work_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt;
  logic              more_r, more_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic              out_last_r;
  logic [7:0]        out_byte_r;
  logic [VAL_W-1:0]  out_val_r;
  logic [CNT_W-1:0]  out_cnt_r;
  status_t           out_st_r;

  logic              out_load;
  kind_t             ld_kind;
  logic              ld_last;
  logic [7:0]        ld_byte;
  logic [VAL_W-1:0]  ld_val;
  logic [CNT_W-1:0]  ld_cnt;
  status_t           ld_st;

  logic              out_free;
  logic              in_acc;
  sh_mode_t          sh_mode;
  logic [VAL_W-1:0]  sh_operand;
  logic [VAL_W-1:0]  sh_res;
  logic [CNT_W-1:0]  seen_inc;
  logic              dec_fin;
  logic              dec_lim;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign sh_mode    = (state_r == S_DEC) ? SH_DEC_LEFT : SH_ENC_RIGHT;
  assign sh_operand = (state_r == S_DEC) ? acc_r : work_r;

  bevc_shift_unit u_shift (
    .mode    (sh_mode),
    .operand (sh_operand),
    .grp_in  (grp_r),
    .result  (sh_res)
  );

  assign seen_inc = seen_r + 4'd1;
  assign dec_fin  = !more_r;
  assign dec_lim  = (seen_inc >= CNT_W'(MAX_BYTES));

  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    val_nxt   = val_r;
    grp_nxt   = grp_r;
    more_nxt  = more_r;
    sel_nxt   = sel_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    out_load  = 1'b0;
    ld_kind   = KIND_ENC;
    ld_last   = 1'b0;
    ld_byte   = '0;
    ld_val    = '0;
    ld_cnt    = '0;
    ld_st     = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          work_nxt = in_tdata[63:0];
          val_nxt  = in_tdata[63:0];
          grp_nxt  = in_tdata[70:64];
          more_nxt = in_tdata[71];
          sel_nxt  = in_tdata[73:72];
          n_nxt    = 4'd1;
          state_nxt = (op_t'(in_tuser) == OP_DECODE) ? S_DEC : S_COUNT;
        end
      end
      S_COUNT: begin
        // One group per cycle until the remaining high part is empty.
        if ((sh_res != '0) && (n_r < CNT_W'(MAX_BYTES))) begin
          n_nxt    = n_r + 4'd1;
          work_nxt = sh_res;
        end else begin
          idx_nxt   = n_r - 4'd1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = KIND_ENC;
          ld_last  = (idx_r == '0);
          ld_byte  = {(idx_r != '0), get_group(val_r, idx_r)};
          ld_cnt   = n_r;
          idx_nxt  = idx_r - 4'd1;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DEC: begin
        // A byte that produces a word waits here for the output slot.
        if (!(dec_fin || dec_lim) || out_free) begin
          state_nxt = S_IDLE;
          if (dec_fin) begin
            out_load = 1'b1;
            ld_kind  = KIND_DEC;
            ld_last  = 1'b1;
            ld_cnt   = seen_inc;
            if (fits_range(sh_res, sel_r)) begin
              ld_val = sh_res;
              ld_st  = ST_OK;
            end else begin
              ld_st  = ST_RANGE;
            end
            acc_nxt  = '0;
            seen_nxt = '0;
          end else if (dec_lim) begin
            out_load = 1'b1;
            ld_kind  = KIND_DEC;
            ld_last  = 1'b1;
            ld_cnt   = seen_inc;
            ld_st    = ST_TOO_LONG;
            acc_nxt  = '0;
            seen_nxt = '0;
          end else begin
            acc_nxt  = sh_res;
            seen_nxt = seen_inc;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    val_r  <= val_nxt;
    grp_r  <= grp_nxt;
    more_r <= more_nxt;
    sel_r  <= sel_nxt;
    if (out_load) begin
      out_kind_r <= ld_kind;
      out_last_r <= ld_last;
      out_byte_r <= ld_byte;
      out_val_r  <= ld_val;
      out_cnt_r  <= ld_cnt;
      out_st_r   <= ld_st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_st_r, out_cnt_r, out_val_r, out_byte_r};

`ifndef SYNTH
  a_seen_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r < CNT_W'(MAX_BYTES))
    else $error("decode byte count reached the limit without being cleared");

  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (idx_r < n_r))
    else $error("encode group index outside the sized length");

  a_enc_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ENC) |-> (out_byte_r[7] == !out_last_r))
    else $error("continuation bit disagrees with the last flag");

  a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ENC) |-> (out_st_r == ST_OK && out_val_r == '0))
    else $error("encode word carries decode status or value");

  a_dec_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_DEC && out_st_r != ST_OK) |-> (out_val_r == '0))
    else $error("failed decode word carries a value");
`endif

endmodule
